>>> rtl/adsr_pkg.sv
`default_nettype none

package adsr_pkg;

  localparam int LEVEL_FRAC_BITS = 24;
  localparam int LEVEL_W         = LEVEL_FRAC_BITS + 1;
  localparam int N_W             = 13;
  localparam int TIME_W          = 24;
  localparam int PCT_W           = 7;
  localparam int STAGE_W         = 3;
  localparam int CFG_IDX_W       = 3;
  localparam int CFG_DATA_W      = 24;

  localparam logic [LEVEL_W-1:0] LEVEL_ONE = {1'b1, {LEVEL_FRAC_BITS{1'b0}}};
  localparam logic [LEVEL_W-1:0] REL_FLOOR =
    LEVEL_W'(((2 ** LEVEL_FRAC_BITS) + 500) / 1000);

  localparam logic [PCT_W-1:0]  PCT_FULL   = PCT_W'(100);
  localparam logic [TIME_W-1:0] TIME_RESET = TIME_W'(48);

  // x / 100 as a reciprocal multiply, exact for x up to 101 * LEVEL_ONE
  localparam int DIV100_SHIFT = LEVEL_FRAC_BITS + 14;
  localparam int DIV100_W     = LEVEL_FRAC_BITS + 8;
  localparam logic [DIV100_W-1:0] DIV100_MUL =
    DIV100_W'(((64'd1 << DIV100_SHIFT) + 64'd99) / 64'd100);

  // serial divider: two quotient bits per cycle
  localparam int DVD_W     = LEVEL_FRAC_BITS + N_W;
  localparam int DSR_W     = TIME_W;
  localparam int DIV_ITER  = (DVD_W + 1) / 2;
  localparam int DIV_PAD_W = 2 * DIV_ITER;
  localparam int DIV_CNT_W = $clog2(DIV_ITER + 1);

  typedef enum logic [1:0] {
    ACT_TICK = 2'd0,
    ACT_ON   = 2'd1,
    ACT_OFF  = 2'd2,
    ACT_KILL = 2'd3
  } action_e;

  typedef enum logic [STAGE_W-1:0] {
    STG_IDLE    = 3'd0,
    STG_ATTACK  = 3'd1,
    STG_DECAY   = 3'd2,
    STG_SUSTAIN = 3'd3,
    STG_RELEASE = 3'd4
  } stage_e;

  typedef enum logic [2:0] {
    CMD_HOLD    = 3'd0,
    CMD_ADVANCE = 3'd1,
    CMD_TRIGGER = 3'd2,
    CMD_RELEASE = 3'd3,
    CMD_KILL    = 3'd4
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ENABLE  = 3'd0,
    CFG_ATTACK  = 3'd1,
    CFG_DECAY   = 3'd2,
    CFG_RELEASE = 3'd3,
    CFG_SUSTAIN = 3'd4,
    CFG_AMOUNT  = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic              env_enable;
    logic [TIME_W-1:0] attack_samples;
    logic [TIME_W-1:0] decay_samples;
    logic [TIME_W-1:0] release_samples;
    logic [PCT_W-1:0]  sustain_percent;
    logic [PCT_W-1:0]  amount_percent;
  } cfg_t;

  typedef struct packed {
    cmd_e           kind;
    logic [N_W-1:0] n;
  } cmd_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] value;
    logic [STAGE_W-1:0] stage;
  } res_t;

  typedef struct packed {
    logic             start;
    logic [DVD_W-1:0] dividend;
    logic [DSR_W-1:0] divisor;
  } div_req_t;

endpackage

`default_nettype wire

>>> rtl/adsr_envelope_generator_top.sv
// Channel   Handshake               Payload
// request   push / full             action_i, block_samples_i
// result    empty / pop             env_value_o, env_stage_o
// config    cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// Request accept to result: a tick with the envelope off goes wait to push; note-on/off/kill add
// the output state, and with it on those and an idle tick add the scaling state; a tick in sustain
// adds the sustain state, in attack or release one radix-4 divider pass, in decay both: 19 steps
// plus load and done; the back takes the next request the cycle after its result.
// Two-entry queues sit at both sides: a full result queue holds the back, then full rises.
// Reset is asynchronous, active low; config registers take their documented defaults.
`default_nettype none

module adsr_envelope_generator_top import adsr_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  push,
  output logic                       full,
  input  wire logic [1:0]            action_i,
  input  wire logic [N_W-1:0]        block_samples_i,
  output logic                       empty,
  input  wire logic                  pop,
  output logic [LEVEL_W-1:0]         env_value_o,
  output logic [STAGE_W-1:0]         env_stage_o,
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  cfg_t             cfg_q;
  logic             cmd_valid, cmd_ready;
  cmd_t             cmd;
  div_req_t         div_req;
  logic             div_done;
  logic [DVD_W-1:0] div_quo;
  logic             res_valid, res_ready;
  res_t             res, res_head;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.env_enable      <= 1'b0;
      cfg_q.attack_samples  <= TIME_RESET;
      cfg_q.decay_samples   <= TIME_RESET;
      cfg_q.release_samples <= TIME_RESET;
      cfg_q.sustain_percent <= PCT_FULL;
      cfg_q.amount_percent  <= PCT_FULL;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_ENABLE:  cfg_q.env_enable      <= cfg_data_i[0];
        CFG_ATTACK:  cfg_q.attack_samples  <= cfg_data_i[TIME_W-1:0];
        CFG_DECAY:   cfg_q.decay_samples   <= cfg_data_i[TIME_W-1:0];
        CFG_RELEASE: cfg_q.release_samples <= cfg_data_i[TIME_W-1:0];
        CFG_SUSTAIN: cfg_q.sustain_percent <= cfg_data_i[PCT_W-1:0];
        CFG_AMOUNT:  cfg_q.amount_percent  <= cfg_data_i[PCT_W-1:0];
        default: ;
      endcase
    end
  end

  adsr_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .env_enable_i    (cfg_q.env_enable),
    .push            (push),
    .full            (full),
    .action_i        (action_i),
    .block_samples_i (block_samples_i),
    .cmd_valid_o     (cmd_valid),
    .cmd_ready_i     (cmd_ready),
    .cmd_o           (cmd)
  );

  adsr_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .done_o (div_done),
    .quo_o  (div_quo)
  );

  adsr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .cmd_valid_i (cmd_valid),
    .cmd_ready_o (cmd_ready),
    .cmd_i       (cmd),
    .div_req_o   (div_req),
    .div_done_i  (div_done),
    .div_quo_i   (div_quo),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  adsr_outq u_outq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_valid),
    .ready_o (res_ready),
    .data_i  (res),
    .empty_o (empty),
    .pop_i   (pop),
    .data_o  (res_head)
  );

  assign env_value_o = res_head.value;
  assign env_stage_o = res_head.stage;

endmodule

`default_nettype wire

>>> rtl/adsr_front.sv
`default_nettype none

module adsr_front import adsr_pkg::*; (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           env_enable_i,
  input  wire logic           push,
  output logic                full,
  input  wire logic [1:0]     action_i,
  input  wire logic [N_W-1:0] block_samples_i,
  output logic                cmd_valid_o,
  input  wire logic           cmd_ready_i,
  output cmd_t                cmd_o
);

  cmd_t       mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;
  cmd_t       cmd_in;
  logic       enq, deq;

  always_comb begin
    cmd_in.n = block_samples_i;
    unique case (action_e'(action_i))
      ACT_TICK: cmd_in.kind = env_enable_i ? CMD_ADVANCE : CMD_HOLD;
      ACT_ON:   cmd_in.kind = CMD_TRIGGER;
      ACT_OFF:  cmd_in.kind = CMD_RELEASE;
      default:  cmd_in.kind = CMD_KILL;
    endcase
  end

  assign full        = (count_q == 2'd2);
  assign cmd_valid_o = (count_q != 2'd0);
  assign cmd_o       = mem_q[rd_ptr_q];
  assign enq         = push && !full;
  assign deq         = cmd_valid_o && cmd_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (enq) wr_ptr_q <= ~wr_ptr_q;
      if (deq) rd_ptr_q <= ~rd_ptr_q;
      count_q <= count_q + {1'b0, enq} - {1'b0, deq};
    end
  end

  always_ff @(posedge clk_i) begin
    if (enq) mem_q[wr_ptr_q] <= cmd_in;
  end

endmodule

`default_nettype wire

>>> rtl/adsr_div.sv
`default_nettype none

module adsr_div import adsr_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire div_req_t   req_i,
  output logic            done_o,
  output logic [DVD_W-1:0] quo_o
);

  logic [DSR_W-1:0]     rem_q, dsr_q;
  logic [DIV_PAD_W-1:0] quo_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic                 busy_q, done_q;

  logic [DSR_W:0]       t1, t2;
  logic                 ge1, ge2;
  logic [DSR_W-1:0]     r1, r2;
  logic [DIV_PAD_W-1:0] s1, s2;

  always_comb begin
    t1  = {rem_q, quo_q[DIV_PAD_W-1]};
    ge1 = (t1 >= {1'b0, dsr_q});
    r1  = ge1 ? DSR_W'(t1 - {1'b0, dsr_q}) : t1[DSR_W-1:0];
    s1  = {quo_q[DIV_PAD_W-2:0], ge1};
    t2  = {r1, s1[DIV_PAD_W-1]};
    ge2 = (t2 >= {1'b0, dsr_q});
    r2  = ge2 ? DSR_W'(t2 - {1'b0, dsr_q}) : t2[DSR_W-1:0];
    s2  = {s1[DIV_PAD_W-2:0], ge2};
  end

  assign done_o = done_q;
  assign quo_o  = quo_q[DVD_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      rem_q  <= '0;
      dsr_q  <= '0;
      quo_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        rem_q  <= '0;
        dsr_q  <= req_i.divisor;
        quo_q  <= DIV_PAD_W'(req_i.dividend);
        cnt_q  <= DIV_CNT_W'(DIV_ITER);
        busy_q <= 1'b1;
      end else if (busy_q) begin
        rem_q <= r2;
        quo_q <= s2;
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == DIV_CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/adsr_back.sv
`default_nettype none

module adsr_back import adsr_pkg::*; (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire cfg_t            cfg_i,
  input  wire logic            cmd_valid_i,
  output logic                 cmd_ready_o,
  input  wire cmd_t            cmd_i,
  output div_req_t             div_req_o,
  input  wire logic            div_done_i,
  input  wire logic [DVD_W-1:0] div_quo_i,
  output logic                 res_valid_o,
  input  wire logic            res_ready_i,
  output res_t                 res_o
);

  typedef enum logic [2:0] {
    BS_WAIT, BS_SUS, BS_STEP, BS_OUT, BS_OUTW, BS_PUSH
  } back_state_e;

  back_state_e              state_q;
  stage_e                   stage_q;
  logic [LEVEL_W-1:0]       level_q, sus_q;
  logic [N_W-1:0]           n_q;
  logic [LEVEL_W+PCT_W-1:0] out_num_q;
  div_req_t                 div_req_q;
  logic                     res_valid_q;
  res_t                     res_q;

  logic [PCT_W-1:0]         sus_pct, amt_pct;
  logic [TIME_W-1:0]        atk_t, dec_t, rel_t;
  logic [LEVEL_W+N_W-1:0]   prod_rel, prod_dec;
  logic [LEVEL_W+PCT_W-1:0] prod_out, sus_num;
  logic [LEVEL_W-1:0]       sus_lvl;
  logic [DVD_W:0]           atk_sum;
  logic [LEVEL_W-1:0]       dec_gap, rel_rem, step_level;
  stage_e                   step_stage;

  function automatic logic [LEVEL_W-1:0] div100(input logic [LEVEL_W+PCT_W-1:0] x);
    logic [LEVEL_W+PCT_W+DIV100_W-1:0] p;
    p = x * DIV100_MUL;
    return p[DIV100_SHIFT +: LEVEL_W];
  endfunction

  always_comb begin
    sus_pct  = (cfg_i.sustain_percent > PCT_FULL) ? PCT_FULL : cfg_i.sustain_percent;
    amt_pct  = (cfg_i.amount_percent > PCT_FULL) ? PCT_FULL : cfg_i.amount_percent;
    atk_t    = (cfg_i.attack_samples == '0) ? TIME_W'(1) : cfg_i.attack_samples;
    dec_t    = (cfg_i.decay_samples == '0) ? TIME_W'(1) : cfg_i.decay_samples;
    rel_t    = (cfg_i.release_samples == '0) ? TIME_W'(1) : cfg_i.release_samples;
    prod_rel = level_q * cmd_i.n;
    prod_dec = n_q * (LEVEL_ONE - sus_q);
    prod_out = level_q * amt_pct;
    sus_num  = sus_pct * LEVEL_ONE + (LEVEL_W + PCT_W)'(50);
    sus_lvl  = div100(sus_num);
  end

  // level update from the divider step
  always_comb begin
    atk_sum    = {1'b0, DVD_W'(level_q)} + {1'b0, div_quo_i};
    dec_gap    = level_q - sus_q;
    rel_rem    = level_q - div_quo_i[LEVEL_W-1:0];
    step_level = level_q;
    step_stage = stage_q;
    unique case (stage_q)
      STG_ATTACK: begin
        if (atk_sum >= (DVD_W + 1)'(LEVEL_ONE)) begin
          step_level = LEVEL_ONE;
          step_stage = STG_DECAY;
        end else begin
          step_level = atk_sum[LEVEL_W-1:0];
        end
      end
      STG_DECAY: begin
        if (level_q <= sus_q || DVD_W'(dec_gap) <= div_quo_i) begin
          step_level = sus_q;
          step_stage = STG_SUSTAIN;
        end else begin
          step_level = level_q - div_quo_i[LEVEL_W-1:0];
        end
      end
      STG_RELEASE: begin
        if (div_quo_i > DVD_W'(level_q) || rel_rem < REL_FLOOR) begin
          step_level = '0;
          step_stage = STG_IDLE;
        end else begin
          step_level = rel_rem;
        end
      end
      default: begin
        step_level = level_q;
      end
    endcase
  end

  assign cmd_ready_o = (state_q == BS_WAIT);
  assign div_req_o   = div_req_q;
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BS_WAIT;
      stage_q     <= STG_IDLE;
      level_q     <= '0;
      sus_q       <= '0;
      n_q         <= '0;
      out_num_q   <= '0;
      div_req_q   <= '0;
      res_valid_q <= 1'b0;
      res_q       <= '0;
    end else begin
      div_req_q.start <= 1'b0;
      unique case (state_q)
        BS_WAIT: begin
          if (cmd_valid_i) begin
            n_q <= cmd_i.n;
            unique case (cmd_i.kind)
              CMD_HOLD: begin
                res_q.value <= '0;
                res_q.stage <= stage_q;
                res_valid_q <= 1'b1;
                state_q     <= BS_PUSH;
              end
              CMD_ADVANCE: begin
                unique case (stage_q)
                  STG_ATTACK: begin
                    div_req_q <= '{start: 1'b1, dividend: {cmd_i.n, {LEVEL_FRAC_BITS{1'b0}}},
                                   divisor: atk_t};
                    state_q   <= BS_STEP;
                  end
                  STG_DECAY, STG_SUSTAIN: begin
                    sus_q   <= sus_lvl;
                    state_q <= BS_SUS;
                  end
                  STG_RELEASE: begin
                    div_req_q <= '{start: 1'b1, dividend: DVD_W'(prod_rel),
                                   divisor: rel_t};
                    state_q   <= BS_STEP;
                  end
                  default: begin
                    level_q <= '0;
                    state_q <= BS_OUT;
                  end
                endcase
              end
              CMD_TRIGGER: begin
                stage_q <= STG_ATTACK;
                level_q <= '0;
                state_q <= BS_OUT;
              end
              CMD_RELEASE: begin
                if (stage_q != STG_IDLE) stage_q <= STG_RELEASE;
                state_q <= BS_OUT;
              end
              default: begin
                stage_q <= STG_IDLE;
                level_q <= '0;
                state_q <= BS_OUT;
              end
            endcase
          end
        end
        BS_SUS: begin
          if (stage_q == STG_SUSTAIN) begin
            level_q <= sus_q;
            state_q <= BS_OUT;
          end else begin
            div_req_q <= '{start: 1'b1, dividend: DVD_W'(prod_dec), divisor: dec_t};
            state_q   <= BS_STEP;
          end
        end
        BS_STEP: begin
          if (div_done_i) begin
            level_q <= step_level;
            stage_q <= step_stage;
            state_q <= BS_OUT;
          end
        end
        BS_OUT: begin
          res_q.stage <= stage_q;
          if (cfg_i.env_enable) begin
            out_num_q <= prod_out;
            state_q   <= BS_OUTW;
          end else begin
            res_q.value <= '0;
            res_valid_q <= 1'b1;
            state_q     <= BS_PUSH;
          end
        end
        BS_OUTW: begin
          res_q.value <= div100(out_num_q);
          res_valid_q <= 1'b1;
          state_q     <= BS_PUSH;
        end
        BS_PUSH: begin
          if (res_ready_i) begin
            res_valid_q <= 1'b0;
            state_q     <= BS_WAIT;
          end
        end
        default: state_q <= BS_WAIT;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_level_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    level_q <= LEVEL_ONE) else $error("level above full scale");

  a_idle_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stage_q == STG_IDLE |-> level_q == '0) else $error("idle with nonzero level");

  a_div_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_req_q.start |-> state_q == BS_STEP)
    else $error("divider started outside a wait state");

  a_res_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q |-> state_q == BS_PUSH) else $error("result valid outside push");
`endif

endmodule

`default_nettype wire

>>> rtl/adsr_outq.sv
`default_nettype none

module adsr_outq import adsr_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  output logic      ready_o,
  input  wire res_t data_i,
  output logic      empty_o,
  input  wire logic pop_i,
  output res_t      data_o
);

  res_t       mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;
  logic       enq, deq;

  assign ready_o = (count_q != 2'd2);
  assign empty_o = (count_q == 2'd0);
  assign data_o  = mem_q[rd_ptr_q];
  assign enq     = push_i && ready_o;
  assign deq     = pop_i && !empty_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (enq) wr_ptr_q <= ~wr_ptr_q;
      if (deq) rd_ptr_q <= ~rd_ptr_q;
      count_q <= count_q + {1'b0, enq} - {1'b0, deq};
    end
  end

  always_ff @(posedge clk_i) begin
    if (enq) mem_q[wr_ptr_q] <= data_i;
  end

endmodule

`default_nettype wire
